// ===== hw/rtl/pidt_pkg.sv =====
// ----------------------------------------------------------------------------
// pidt_pkg: shared types and constants for the process id table
// Field widths, action/state/status codes, table entry and result layouts,
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package pidt_pkg;

  localparam int ID_SLOTS_DEF = 256;
  localparam int FIRST_ID_DEF = 2;

  localparam int ACT_W  = 3;
  localparam int ID_W   = 8;
  localparam int PAR_W  = 9;
  localparam int CODE_W = 32;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  localparam logic [PAR_W-1:0] INIT_ID   = 9'd1;
  localparam logic [PAR_W-1:0] NO_PARENT = 9'h1FF;

  typedef enum logic [ACT_W-1:0] {
    ACT_ALLOC   = 3'd0,
    ACT_EXIT    = 3'd1,
    ACT_WAIT    = 3'd2,
    ACT_DESTROY = 3'd3,
    ACT_QUERY   = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_USED    = 2'd1,
    ST_ZOMBIE  = 2'd2,
    ST_INVALID = 2'd3
  } st_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_ID      = 2'd1,
    STAT_NOT_EXITED = 2'd2
  } stat_t;

  // input word, lowest field last
  typedef struct packed {
    logic [CODE_W-1:0] exit_value;
    logic [PAR_W-1:0]  parent_id;
    logic [ID_W-1:0]   target_id;
    logic [ACT_W-1:0]  action;
  } item_t;

  // result word, lowest field last
  typedef struct packed {
    logic [CODE_W-1:0] exit_out;
    logic [PAR_W-1:0]  parent_out;
    st_t               slot_state;
    logic [ID_W-1:0]   given_id;
    stat_t             status;
  } res_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [PAR_W-1:0]  parent;
    st_t               st;
  } entry_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic tgt_rd;
    logic tgt_do;
    logic scan_rd;
    logic out_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] in_act;
    logic             in_tgt_ok;
    logic [ACT_W-1:0] act;
    logic             tgt_live;
    logic             cnt_end;
    logic             pend;
    logic             out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/process_id_table.sv =====
// ----------------------------------------------------------------------------
// process_id_table: process id allocator with parent and exit bookkeeping
// One word in, one result word out per item; allocate, exit, wait, destroy
// and query on a table memory with one write port and one read port.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata  action, target_id, parent_id, exit_value
//  out_    | out | out_tvalid/tready  | out_tdata status, given_id, slot_state,
//          |     |                    |           parent_out, exit_out
//
//  Allocate scans the table from FIRST_ID up, one table entry per cycle.
//  Exit of a live id reads its target entry and then scans the whole table;
//  wait/destroy/query touch only the target entry; an invalid target or
//  unknown action goes straight to the result.
//  After reset a clear pass over all ID_SLOTS entries runs before in_tready rises.
//  A pending result in the output register does not block the next word;
//  only loading the following result waits for out_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module process_id_table #(
  parameter int ID_SLOTS = pidt_pkg::ID_SLOTS_DEF,
  parameter int FIRST_ID = pidt_pkg::FIRST_ID_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [2:0] action, [10:3] target_id, [19:11] parent_id, [51:20] exit_value
  input  wire logic [pidt_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [1:0] status, [9:2] given_id, [11:10] slot_state, [20:12] parent_out,
  // [52:21] exit_out
  output logic [pidt_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  pidt_pkg::ctrl_cmd_t cmd;
  pidt_pkg::dp_stat_t  st;

  pidt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  pidt_dp #(
    .ID_SLOTS (ID_SLOTS),
    .FIRST_ID (FIRST_ID)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted word did not take the block busy");

  a_given_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[9:2] != 8'd0) |-> out_tdata[1:0] == pidt_pkg::STAT_OK)
    else $error("id handed out with non-ok status");

  a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[11:10] == pidt_pkg::ST_INVALID) |->
      (out_tdata[20:12] == pidt_pkg::NO_PARENT) && (out_tdata[52:21] == 32'd0))
    else $error("invalid query result carries table data");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pidt_dp.sv =====
// ----------------------------------------------------------------------------
// pidt_dp: process id table datapath
// Table memory, scan counter, read-modify-write pipe, result and output
// registers. Driven by commands from pidt_ctrl.
// ----------------------------------------------------------------------------
`default_nettype none

module pidt_dp #(
  parameter int ID_SLOTS = pidt_pkg::ID_SLOTS_DEF,
  parameter int FIRST_ID = pidt_pkg::FIRST_ID_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [pidt_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  wire pidt_pkg::ctrl_cmd_t                cmd,
  output pidt_pkg::dp_stat_t                      st,
  input  wire logic                               out_tready,
  output logic                                    out_tvalid,
  output logic [pidt_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  localparam int AW      = $clog2(ID_SLOTS);
  localparam int CW      = $clog2(ID_SLOTS + 1);
  localparam int SCAN_LO = (FIRST_ID < ID_SLOTS) ? FIRST_ID : ID_SLOTS;
  localparam int IN_W    = $bits(pidt_pkg::item_t);
  localparam int OUT_PAD = pidt_pkg::OUT_TDATA_W - $bits(pidt_pkg::res_t);

  pidt_pkg::entry_t mem [ID_SLOTS];
  pidt_pkg::entry_t rd_data_r;
  pidt_pkg::entry_t wr_data;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;

  pidt_pkg::item_t  in_item;
  pidt_pkg::res_t   res_dflt;
  pidt_pkg::res_t   res_r;
  pidt_pkg::res_t   out_r;

  logic [pidt_pkg::ACT_W-1:0]  act_r;
  logic [pidt_pkg::ID_W-1:0]   tid_r;
  logic [pidt_pkg::PAR_W-1:0]  par_r;
  logic [pidt_pkg::CODE_W-1:0] code_r;
  logic                        found_r;
  logic [CW-1:0]               cnt_r;
  logic [AW-1:0]               pa_r;
  logic                        pv_r;
  logic                        out_tvalid_r;

  logic [15:0]   tid_w;
  logic [15:0]   pa_w;
  logic [AW-1:0] tid_a;
  logic          freed;
  logic          hit;
  logic          self_hit;
  logic          found_set;

  assign in_item = pidt_pkg::item_t'(in_tdata[IN_W-1:0]);
  assign tid_w   = 16'(tid_r);
  assign tid_a   = tid_w[AW-1:0];
  assign pa_w    = 16'(pa_r);
  assign rd_addr = cmd.tgt_rd ? tid_a : cnt_r[AW-1:0];

  assign freed    = (rd_data_r.st == pidt_pkg::ST_ZOMBIE) &&
                    (rd_data_r.parent == pidt_pkg::INIT_ID);
  assign hit      = (rd_data_r.parent == {1'b0, tid_r});
  assign self_hit = (pa_r == tid_a);

  assign st.in_act    = in_item.action;
  assign st.in_tgt_ok = (17'(in_item.target_id) >= 17'(FIRST_ID)) &&
                        (17'(in_item.target_id) < 17'(ID_SLOTS));
  assign st.act       = act_r;
  assign st.tgt_live  = (rd_data_r.st != pidt_pkg::ST_FREE);
  assign st.cnt_end   = (cnt_r == CW'(ID_SLOTS));
  assign st.pend      = pv_r;
  assign st.out_busy  = out_tvalid_r && !out_tready;

  always_comb begin
    res_dflt            = '0;
    res_dflt.status     = pidt_pkg::STAT_OK;
    res_dflt.slot_state = pidt_pkg::ST_FREE;
    if (in_item.action == pidt_pkg::ACT_ALLOC) begin
      res_dflt.status = pidt_pkg::STAT_NO_ID;
    end
    if (in_item.action == pidt_pkg::ACT_WAIT) begin
      res_dflt.status = pidt_pkg::STAT_NOT_EXITED;
    end
    if (in_item.action == pidt_pkg::ACT_QUERY) begin
      res_dflt.slot_state = pidt_pkg::ST_INVALID;
      res_dflt.parent_out = pidt_pkg::NO_PARENT;
    end
  end

  // at most one table write per cycle: clear pass, target update or scan update
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = pa_r;
    wr_data   = rd_data_r;
    found_set = 1'b0;
    priority if (cmd.clr) begin
      wr_en          = 1'b1;
      wr_addr        = cnt_r[AW-1:0];
      wr_data.code   = '0;
      wr_data.parent = pidt_pkg::NO_PARENT;
      wr_data.st     = (17'(cnt_r) < 17'(FIRST_ID)) ? pidt_pkg::ST_USED
                                                    : pidt_pkg::ST_FREE;
    end else if (cmd.tgt_do) begin
      wr_addr = tid_a;
      if ((act_r == pidt_pkg::ACT_DESTROY) ||
          ((act_r == pidt_pkg::ACT_WAIT) && (rd_data_r.st == pidt_pkg::ST_ZOMBIE))) begin
        wr_en          = 1'b1;
        wr_data.parent = pidt_pkg::NO_PARENT;
        wr_data.st     = pidt_pkg::ST_FREE;
      end
    end else if (pv_r) begin
      if (act_r == pidt_pkg::ACT_ALLOC) begin
        if (!found_r && (freed || (rd_data_r.st == pidt_pkg::ST_FREE))) begin
          wr_en          = 1'b1;
          wr_data.parent = par_r;
          wr_data.st     = pidt_pkg::ST_USED;
          found_set      = 1'b1;
        end else if (freed) begin
          wr_en          = 1'b1;
          wr_data.parent = pidt_pkg::NO_PARENT;
          wr_data.st     = pidt_pkg::ST_FREE;
        end
      end else begin
        if (hit || self_hit) begin
          wr_en = 1'b1;
          if (hit) begin
            wr_data.parent = pidt_pkg::INIT_ID;
          end
          if (self_hit) begin
            wr_data.code = code_r;
            wr_data.st   = pidt_pkg::ST_ZOMBIE;
          end
        end
      end
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      pv_r         <= 1'b0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      pv_r <= cmd.scan_rd;
      if (cmd.load) begin
        cnt_r   <= (in_item.action == pidt_pkg::ACT_ALLOC) ? CW'(SCAN_LO) : '0;
        found_r <= 1'b0;
      end else if (cmd.clr || cmd.scan_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (found_set) begin
        found_r <= 1'b1;
      end
      if (cmd.out_ld) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_item.action;
      tid_r  <= in_item.target_id;
      par_r  <= in_item.parent_id;
      code_r <= in_item.exit_value;
      res_r  <= res_dflt;
    end
    if (cmd.scan_rd) begin
      pa_r <= cnt_r[AW-1:0];
    end
    if (found_set) begin
      res_r.given_id <= pa_w[pidt_pkg::ID_W-1:0];
      res_r.status   <= pidt_pkg::STAT_OK;
    end
    if (cmd.tgt_do) begin
      if ((act_r == pidt_pkg::ACT_WAIT) && (rd_data_r.st == pidt_pkg::ST_ZOMBIE)) begin
        res_r.exit_out <= rd_data_r.code;
        res_r.status   <= pidt_pkg::STAT_OK;
      end
      if (act_r == pidt_pkg::ACT_QUERY) begin
        res_r.slot_state <= rd_data_r.st;
        res_r.parent_out <= rd_data_r.parent;
        res_r.exit_out   <= rd_data_r.code;
      end
    end
    if (cmd.out_ld) begin
      out_r <= res_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_r};

endmodule

`default_nettype wire

// ===== hw/rtl/pidt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pidt_ctrl: process id table controller
// Sequences the clear pass, target read, table scans and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module pidt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire pidt_pkg::dp_stat_t st,
  output pidt_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_TGT_RD,
    S_TGT_CHK,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = !st.cnt_end;
        if (st.cnt_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          unique case (pidt_pkg::act_t'(st.in_act))
            pidt_pkg::ACT_ALLOC: state_nxt = S_SCAN;
            pidt_pkg::ACT_EXIT,
            pidt_pkg::ACT_WAIT,
            pidt_pkg::ACT_DESTROY,
            pidt_pkg::ACT_QUERY: state_nxt = st.in_tgt_ok ? S_TGT_RD : S_DONE;
            default:             state_nxt = S_DONE;
          endcase
        end
      end
      S_TGT_RD: begin
        cmd.tgt_rd = 1'b1;
        state_nxt  = S_TGT_CHK;
      end
      S_TGT_CHK: begin
        cmd.tgt_do = 1'b1;
        if ((st.act == pidt_pkg::ACT_EXIT) && st.tgt_live) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = !st.cnt_end;
        if (st.cnt_end && !st.pend) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: process id table stream test
// Drives allocate, exit, wait, destroy, query and unknown-action words into the table,
// predicts every result word from a private copy of the id table, and
// compares each returned word field by field. Both sides idle in random
// bursts, and the result side holds off once long enough to back up the
// input side.
// ----------------------------------------------------------------------------
module testbench;
  import pidt_pkg::*;

  localparam int SLOTS = ID_SLOTS_DEF;
  localparam int LOW_ID = FIRST_ID_DEF;
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
  localparam int RANDOM_WORDS = 2000;
  localparam int TAIL_WORDS = 150;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 600;

  class pid_table_scoreboard;
    st_t               slot_st[SLOTS];
    logic [PAR_W-1:0]  parent_tab[SLOTS];
    logic [CODE_W-1:0] code_tab[SLOTS];
    res_t              pending[$];
    int                errors;

    function new();
      int i;
      for (i = 0; i < SLOTS; i++) begin
        slot_st[i] = (i < LOW_ID) ? ST_USED : ST_FREE;
        parent_tab[i] = NO_PARENT;
        code_tab[i] = '0;
      end
      errors = 0;
    endfunction

    function bit is_live_id(int id);
      return id >= LOW_ID && id < SLOTS;
    endfunction

    function void free_id(int id);
      slot_st[id] = ST_FREE;
      parent_tab[id] = NO_PARENT;
    endfunction

    function int top_live();
      int i;
      int top;
      top = LOW_ID;
      for (i = LOW_ID; i < SLOTS; i++)
        if (slot_st[i] != ST_FREE) top = i;
      return top;
    endfunction

    function void note_item(item_t w);
      res_t r;
      int   i;
      int   tid;
      r = '0;
      tid = w.target_id;
      case (w.action)
        ACT_ALLOC: begin
          // init reaps its zombies before the scan for a free id
          for (i = LOW_ID; i < SLOTS; i++)
            if (parent_tab[i] == INIT_ID && slot_st[i] == ST_ZOMBIE) free_id(i);
          r.status = STAT_NO_ID;
          for (i = LOW_ID; i < SLOTS; i++)
            if (slot_st[i] == ST_FREE) begin
              slot_st[i] = ST_USED;
              parent_tab[i] = w.parent_id;
              r.given_id = ID_W'(i);
              r.status = STAT_OK;
              break;
            end
        end
        ACT_EXIT: begin
          if (is_live_id(tid) && slot_st[tid] != ST_FREE) begin
            for (i = 0; i < SLOTS; i++)
              if (parent_tab[i] == PAR_W'(tid)) parent_tab[i] = INIT_ID;
            code_tab[tid] = w.exit_value;
            slot_st[tid] = ST_ZOMBIE;
          end
        end
        ACT_WAIT: begin
          if (is_live_id(tid) && slot_st[tid] == ST_ZOMBIE) begin
            r.exit_out = code_tab[tid];
            free_id(tid);
          end else begin
            r.status = STAT_NOT_EXITED;
          end
        end
        ACT_DESTROY: begin
          if (is_live_id(tid)) free_id(tid);
        end
        ACT_QUERY: begin
          if (is_live_id(tid)) begin
            r.slot_state = slot_st[tid];
            r.parent_out = parent_tab[tid];
            r.exit_out = code_tab[tid];
          end else begin
            r.slot_state = ST_INVALID;
            r.parent_out = NO_PARENT;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void compare_field(string name, logic [CODE_W-1:0] want,
                                logic [CODE_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none actual %0h", $time, got);
        return;
      end
      want = pending.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("given_id", want.given_id, got.given_id);
      compare_field("slot_state", want.slot_state, got.slot_state);
      compare_field("parent_out", want.parent_out, got.parent_out);
      compare_field("exit_out", want.exit_out, got.exit_out);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  bit                     tail_phase = 1'b0;

  pid_table_scoreboard sb = new();

  process_id_table DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic send_word(input item_t w);
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(w);
    do @(posedge clk); while (!in_tready);
    sb.note_item(w);
  endtask

  task automatic maybe_pause(input int k);
    if (!tail_phase && (k / 100) % 4 != 3 && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic issue(input int k, input logic [ACT_W-1:0] act, input int tid,
                       input logic [PAR_W-1:0] par, input logic [CODE_W-1:0] code);
    item_t w;
    w.action = act;
    w.target_id = ID_W'(tid);
    w.parent_id = par;
    w.exit_value = code;
    maybe_pause(k);
    send_word(w);
  endtask

  function automatic item_t random_word(int k);
    item_t w;
    int    top;
    int    span;
    int    roll;
    int    a, e, wt, d;
    top = sb.top_live();
    span = (top + 2 > 255) ? 255 : top + 2;
    roll = $urandom_range(0, 99);
    if (k >= 600 && k < 870) begin
      w.action = ACT_ALLOC;
    end else begin
      if (k < 600) begin
        a = 45; e = 20; wt = 15; d = 5;
      end else if (k < 1400) begin
        a = 12; e = 30; wt = 25; d = 13;
      end else begin
        a = 35; e = 22; wt = 18; d = 8;
      end
      if (roll < a) w.action = ACT_ALLOC;
      else if (roll < a + e) w.action = ACT_EXIT;
      else if (roll < a + e + wt) w.action = ACT_WAIT;
      else if (roll < a + e + wt + d) w.action = ACT_DESTROY;
      else if (roll < 99) w.action = ACT_QUERY;
      else w.action = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    end
    if ($urandom_range(0, 4) == 0) w.target_id = ID_W'($urandom_range(0, 255));
    else w.target_id = ID_W'($urandom_range(0, span));
    roll = $urandom_range(0, 99);
    if (roll < 30) w.parent_id = INIT_ID;
    else if (roll < 45) w.parent_id = NO_PARENT;
    else if (roll < 85) w.parent_id = PAR_W'($urandom_range(0, span));
    else w.parent_id = PAR_W'($urandom_range(0, 255));
    case ($urandom_range(0, 11))
      0: w.exit_value = 32'h8000_0000;
      1: w.exit_value = 32'h7FFF_FFFF;
      2: w.exit_value = '0;
      3: w.exit_value = '1;
      default: w.exit_value = $urandom;
    endcase
    return w;
  endfunction

  initial begin
    int k;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    issue(0, ACT_QUERY, 0, NO_PARENT, '0);
    issue(1, ACT_QUERY, 1, NO_PARENT, '0);
    issue(2, ACT_QUERY, 255, NO_PARENT, '0);
    issue(3, ACT_ALLOC, 0, NO_PARENT, '0);
    issue(4, ACT_ALLOC, 0, 9'd255, '1);
    issue(5, ACT_ALLOC, 255, 9'd2, '0);
    issue(6, ACT_ALLOC, 0, INIT_ID, '0);
    issue(7, ACT_EXIT, 2, 9'd0, 32'h7FFF_FFFF);
    issue(8, ACT_QUERY, 4, NO_PARENT, '0);
    issue(9, ACT_EXIT, 2, 9'd0, 32'h8000_0000);
    issue(10, ACT_WAIT, 2, NO_PARENT, '0);
    issue(11, ACT_WAIT, 2, NO_PARENT, '0);
    issue(12, ACT_WAIT, 3, NO_PARENT, '0);
    issue(13, ACT_EXIT, 4, 9'd0, '1);
    issue(14, ACT_ALLOC, 0, 9'd0, '0);
    issue(15, ACT_QUERY, 4, NO_PARENT, '0);
    issue(16, ACT_EXIT, 255, 9'd0, 32'd5);
    issue(17, ACT_EXIT, 1, 9'd0, 32'd5);
    issue(18, ACT_DESTROY, 0, NO_PARENT, '0);
    issue(19, ACT_WAIT, 1, NO_PARENT, '0);
    issue(20, ACT_DESTROY, 100, NO_PARENT, '0);
    issue(21, ACT_DESTROY, 3, NO_PARENT, '0);
    issue(22, ACT_QUERY, 3, NO_PARENT, '0);
    issue(23, ACT_SPARE_LO, 7, 9'd7, '1);
    issue(24, ACT_SPARE_HI, 255, NO_PARENT, '1);

    // fill window in the middle drives the table to exhaustion
    for (k = 0; k < RANDOM_WORDS; k++) begin
      if (k >= RANDOM_WORDS - TAIL_WORDS) tail_phase = 1'b1;
      maybe_pause(k);
      send_word(random_word(k));
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int stall_left;
    int hold_left;
    int seen;
    int cyc;
    bit held;
    stall_left = 0;
    hold_left = 0;
    seen = 0;
    cyc = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(res_t'(out_tdata[$bits(res_t)-1:0]));
        seen++;
      end
      if (!held && seen >= 40) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0 && !tail_phase) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!tail_phase && cyc % 3000 < 2000 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

endmodule

// ===== process_id_table.f =====
hw/rtl/pidt_pkg.sv
hw/rtl/pidt_dp.sv
hw/rtl/pidt_ctrl.sv
hw/rtl/process_id_table.sv
verif/testbench.sv
